FILE: design/bzi_pkg.sv
// Package for the block-zone interlock: zone, mode and command codes,
// the state and result structs, and the pre-station/ride release rules.
// No dependencies.
package bzi_pkg;

    localparam int ZoneW = 2;
    localparam int CmdW  = 2;
    localparam int ModeW = 3;

    typedef logic [ZoneW-1:0] zone_t;
    typedef logic [CmdW-1:0]  cmd_t;

    localparam zone_t Z_EMPTY    = 2'd0;
    localparam zone_t Z_ENTERING = 2'd1;
    localparam zone_t Z_ENTERED  = 2'd2;

    localparam cmd_t C_NONE     = 2'd0;
    localparam cmd_t C_STOP     = 2'd1;
    localparam cmd_t C_FWD      = 2'd2;
    localparam cmd_t C_ZERO     = 2'd3;
    localparam cmd_t C_REL_STOP = 2'd2;
    localparam cmd_t C_REL_GO   = 2'd3;

    typedef enum logic [ModeW-1:0] {
        M_STOP   = 3'd0,
        M_AUTO   = 3'd1,
        M_MANUAL = 3'd2,
        M_MAINT  = 3'd3,
        M_SAFE   = 3'd4
    } mode_t;

    // Persistent interlock state carried from one item to the next.
    typedef struct packed {
        mode_t mode;
        logic  release_flag;
    } state_t;

    typedef struct packed {
        cmd_t  lift_cmd;
        cmd_t  station_cmd;
        cmd_t  prestation_cmd;
        cmd_t  ride_cmd;
        logic  release_request;
        mode_t mode_now;
    } result_t;

    // Pre-station or ride rule while trains run (automatic and manual).
    function automatic cmd_t run_release(zone_t self_z, zone_t feeder_z, zone_t next_z);
        cmd_t c;
        if (self_z == Z_EMPTY && feeder_z == Z_ENTERED) c = C_REL_STOP;
        else if (self_z == Z_EMPTY) c = C_STOP;
        else if (self_z == Z_ENTERING) c = C_REL_STOP;
        else if (self_z == Z_ENTERED && next_z == Z_EMPTY) c = C_REL_GO;
        else if (self_z == Z_ENTERED) c = C_STOP;
        else c = C_NONE;
        return c;
    endfunction

    // Pre-station or ride rule while trains are brought to rest.
    function automatic cmd_t hold_release(zone_t self_z);
        cmd_t c;
        if (self_z == Z_EMPTY) c = C_STOP;
        else if (self_z == Z_ENTERING) c = C_REL_STOP;
        else c = C_NONE;
        return c;
    endfunction

endpackage

FILE: design/bzi_decide.sv
// Combinational decision logic of the block-zone interlock: mode update,
// per-zone command chains and the release flag update.
// Depends on bzi_pkg.
module bzi_decide (
    input  bzi_pkg::zone_t   lift_zone,
    input  bzi_pkg::zone_t   station_zone,
    input  bzi_pkg::zone_t   prestation_zone,
    input  bzi_pkg::zone_t   ride_zone,
    input  logic             mode_valid,
    input  logic [2:0]       mode_code,
    input  logic             release_granted,
    input  bzi_pkg::state_t  state_cur,
    output bzi_pkg::state_t  state_new,
    output bzi_pkg::result_t result
);

    bzi_pkg::mode_t mode;
    logic           flag_old;
    logic           flag;
    logic           manual;
    logic           may_leave;

    always_comb
    begin
        // Codes beyond return-to-safe carry no mode and are ignored.
        if (mode_valid && mode_code <= bzi_pkg::M_SAFE)
            mode = bzi_pkg::mode_t'(mode_code);
        else
            mode = state_cur.mode;

        flag_old  = state_cur.release_flag;
        flag      = flag_old;
        manual    = (mode == bzi_pkg::M_MANUAL);
        may_leave = !manual || flag_old;

        result = '0;
        result.mode_now = mode;

        unique case (mode) inside
            bzi_pkg::M_AUTO, bzi_pkg::M_MANUAL:
            begin
                if (lift_zone == bzi_pkg::Z_EMPTY && station_zone == bzi_pkg::Z_ENTERED
                    && may_leave)
                    result.lift_cmd = bzi_pkg::C_FWD;
                else if (lift_zone == bzi_pkg::Z_EMPTY)
                    result.lift_cmd = bzi_pkg::C_STOP;
                else if (lift_zone == bzi_pkg::Z_ENTERING)
                    result.lift_cmd = bzi_pkg::C_FWD;
                else if (lift_zone == bzi_pkg::Z_ENTERED && ride_zone == bzi_pkg::Z_EMPTY)
                    result.lift_cmd = bzi_pkg::C_FWD;
                else
                    result.lift_cmd = bzi_pkg::C_STOP;

                if (station_zone == bzi_pkg::Z_EMPTY && prestation_zone == bzi_pkg::Z_ENTERED)
                    result.station_cmd = bzi_pkg::C_FWD;
                else if (station_zone == bzi_pkg::Z_EMPTY)
                    result.station_cmd = bzi_pkg::C_STOP;
                else if (station_zone == bzi_pkg::Z_ENTERING)
                    result.station_cmd = bzi_pkg::C_FWD;
                else if (station_zone == bzi_pkg::Z_ENTERED && lift_zone == bzi_pkg::Z_EMPTY)
                begin
                    if (manual)
                    begin
                        // Ask the operator until a grant comes; the grant is latched.
                        if (!flag_old)
                        begin
                            result.release_request = 1'b1;
                            flag = release_granted;
                        end
                        result.station_cmd = flag ? bzi_pkg::C_FWD : bzi_pkg::C_STOP;
                    end
                    else
                    begin
                        result.station_cmd = bzi_pkg::C_FWD;
                    end
                end
                else if (station_zone == bzi_pkg::Z_ENTERED)
                begin
                    flag = 1'b0;
                    result.station_cmd = bzi_pkg::C_ZERO;
                end
                else
                begin
                    flag = 1'b0;
                    result.station_cmd = bzi_pkg::C_STOP;
                end

                result.prestation_cmd = bzi_pkg::run_release(prestation_zone, ride_zone,
                                                             station_zone);
                result.ride_cmd = bzi_pkg::run_release(ride_zone, lift_zone, prestation_zone);
            end
            bzi_pkg::M_STOP:
            begin
                result.lift_cmd       = bzi_pkg::C_STOP;
                result.station_cmd    = bzi_pkg::C_STOP;
                flag                  = 1'b0;
                result.prestation_cmd = bzi_pkg::hold_release(prestation_zone);
                result.ride_cmd       = bzi_pkg::hold_release(ride_zone);
            end
            bzi_pkg::M_SAFE:
            begin
                if (lift_zone == bzi_pkg::Z_EMPTY || lift_zone == bzi_pkg::Z_ENTERED)
                    result.lift_cmd = bzi_pkg::C_STOP;
                if (station_zone == bzi_pkg::Z_EMPTY)
                    result.station_cmd = bzi_pkg::C_STOP;
                else if (station_zone == bzi_pkg::Z_ENTERING)
                    result.station_cmd = bzi_pkg::C_FWD;
                else if (station_zone == bzi_pkg::Z_ENTERED)
                begin
                    flag = 1'b0;
                    result.station_cmd = bzi_pkg::C_ZERO;
                end
                result.prestation_cmd = bzi_pkg::hold_release(prestation_zone);
                result.ride_cmd       = bzi_pkg::hold_release(ride_zone);
            end
            default:
            begin
                // Maintenance: no commands, flag kept.
            end
        endcase

        state_new.mode         = mode;
        state_new.release_flag = flag;
    end

endmodule

FILE: design/block_zone_interlock.sv
// Block-zone interlock for a four-zone coaster: takes one zone tick per item
// and returns the zone commands through a registered output stage.
// Depends on bzi_pkg and bzi_decide.
//
// Each accepted tick produces exactly one registered result item. The decision
// is a single pass of shallow logic from the input ports into the result
// register, so a new tick is accepted every clock cycle as long as the result
// register is empty or being drained in the same cycle; the rate is one item
// per cycle, limited only by out_ready. The mode starts at stop after reset and
// the release flag starts clear.
module block_zone_interlock (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  bzi_pkg::zone_t       lift_zone,
    input  bzi_pkg::zone_t       station_zone,
    input  bzi_pkg::zone_t       prestation_zone,
    input  bzi_pkg::zone_t       ride_zone,
    input  logic                 mode_valid,
    input  logic [2:0]           mode_code,
    input  logic                 release_granted,
    output logic                 out_valid,
    input  logic                 out_ready,
    output bzi_pkg::cmd_t        lift_cmd,
    output bzi_pkg::cmd_t        station_cmd,
    output bzi_pkg::cmd_t        prestation_cmd,
    output bzi_pkg::cmd_t        ride_cmd,
    output logic                 release_request,
    output logic [2:0]           mode_now
);

    bzi_pkg::state_t  state_reg;
    bzi_pkg::state_t  state_next;
    bzi_pkg::result_t result_reg;
    bzi_pkg::result_t result_next;
    logic             out_valid_reg;
    logic             in_accept;

    bzi_decide u_decide (
        .lift_zone       (lift_zone),
        .station_zone    (station_zone),
        .prestation_zone (prestation_zone),
        .ride_zone       (ride_zone),
        .mode_valid      (mode_valid),
        .mode_code       (mode_code),
        .release_granted (release_granted),
        .state_cur       (state_reg),
        .state_new       (state_next),
        .result          (result_next)
    );

    assign in_ready  = !out_valid_reg || out_ready;
    assign in_accept = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg.mode         <= bzi_pkg::M_STOP;
            state_reg.release_flag <= 1'b0;
            out_valid_reg          <= 1'b0;
        end
        else
        begin
            if (in_accept)
                state_reg <= state_next;
            if (in_accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
            result_reg <= result_next;
    end

    assign out_valid       = out_valid_reg;
    assign lift_cmd        = result_reg.lift_cmd;
    assign station_cmd     = result_reg.station_cmd;
    assign prestation_cmd  = result_reg.prestation_cmd;
    assign ride_cmd        = result_reg.ride_cmd;
    assign release_request = result_reg.release_request;
    assign mode_now        = result_reg.mode_now;

    // The operator is only asked in manual mode.
    a_req_manual: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && release_request |-> mode_now == bzi_pkg::M_MANUAL)
        else $error("release request outside manual mode");

    // Maintenance sends nothing to any zone.
    a_maint_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && mode_now == bzi_pkg::M_MAINT |->
            lift_cmd == bzi_pkg::C_NONE && station_cmd == bzi_pkg::C_NONE &&
            prestation_cmd == bzi_pkg::C_NONE && ride_cmd == bzi_pkg::C_NONE)
        else $error("command issued in maintenance mode");

    // Stop mode always leaves the release flag clear.
    a_stop_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && state_next.mode == bzi_pkg::M_STOP |=> !state_reg.release_flag)
        else $error("release flag set after a stop tick");

    // The reported mode is the mode kept for the next tick.
    a_mode_track: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid && mode_now == state_reg.mode)
        else $error("reported mode differs from kept mode");

endmodule

FILE: tb/tb_top.sv
`timescale 1ns / 1ps
// Self-checking testbench for block_zone_interlock: directed zone ticks, then random
// ones under several handshake idling patterns, checked against a built-in predictor.
// Depends on bzi_pkg and the block_zone_interlock RTL.

import bzi_pkg::*;

class interlock_scoreboard;
    mode_t     op_mode;
    logic      release_latched;
    result_t   expected_cmds[$];
    int        mismatches;

    function new();
        op_mode = M_STOP;
        release_latched = 1'b0;
        mismatches = 0;
    endfunction

    // Pre-station and ride while trains run: move only into a free zone.
    function cmd_t advance_cmd(zone_t self_z, zone_t behind_z, zone_t ahead_z);
        if (self_z == Z_EMPTY)
            return (behind_z == Z_ENTERED) ? C_REL_STOP : C_STOP;
        if (self_z == Z_ENTERING)
            return C_REL_STOP;
        if (self_z == Z_ENTERED)
            return (ahead_z == Z_EMPTY) ? C_REL_GO : C_STOP;
        return C_NONE;
    endfunction

    // Pre-station and ride while trains are brought to rest.
    function cmd_t hold_cmd(zone_t self_z);
        if (self_z == Z_EMPTY)
            return C_STOP;
        if (self_z == Z_ENTERING)
            return C_REL_STOP;
        return C_NONE;
    endfunction

    function void note_tick(zone_t lz, zone_t sz, zone_t pz, zone_t rz,
                            logic mv, logic [2:0] mc, logic granted);
        result_t r;
        logic    manual;
        logic    may_leave;
        r.lift_cmd = C_NONE;
        r.station_cmd = C_NONE;
        r.prestation_cmd = C_NONE;
        r.ride_cmd = C_NONE;
        r.release_request = 1'b0;
        if (mv && mc <= M_SAFE)
            op_mode = mode_t'(mc);
        case (op_mode)
            M_AUTO, M_MANUAL:
            begin
                manual = (op_mode == M_MANUAL);
                // The lift looks at the grant as it stood before this tick.
                may_leave = !manual || release_latched;
                if (lz == Z_EMPTY)
                    r.lift_cmd = (sz == Z_ENTERED && may_leave) ? C_FWD : C_STOP;
                else if (lz == Z_ENTERING)
                    r.lift_cmd = C_FWD;
                else if (lz == Z_ENTERED && rz == Z_EMPTY)
                    r.lift_cmd = C_FWD;
                else
                    r.lift_cmd = C_STOP;

                if (sz == Z_EMPTY)
                    r.station_cmd = (pz == Z_ENTERED) ? C_FWD : C_STOP;
                else if (sz == Z_ENTERING)
                    r.station_cmd = C_FWD;
                else if (sz == Z_ENTERED && lz == Z_EMPTY)
                begin
                    if (manual)
                    begin
                        if (!release_latched)
                        begin
                            r.release_request = 1'b1;
                            release_latched = granted;
                        end
                        r.station_cmd = release_latched ? C_FWD : C_STOP;
                    end
                    else
                        r.station_cmd = C_FWD;
                end
                else if (sz == Z_ENTERED)
                begin
                    release_latched = 1'b0;
                    r.station_cmd = C_ZERO;
                end
                else
                begin
                    release_latched = 1'b0;
                    r.station_cmd = C_STOP;
                end
                r.prestation_cmd = advance_cmd(pz, rz, sz);
                r.ride_cmd = advance_cmd(rz, lz, pz);
            end
            M_STOP:
            begin
                r.lift_cmd = C_STOP;
                r.station_cmd = C_STOP;
                release_latched = 1'b0;
                r.prestation_cmd = hold_cmd(pz);
                r.ride_cmd = hold_cmd(rz);
            end
            M_SAFE:
            begin
                if (lz == Z_EMPTY || lz == Z_ENTERED)
                    r.lift_cmd = C_STOP;
                if (sz == Z_EMPTY)
                    r.station_cmd = C_STOP;
                else if (sz == Z_ENTERING)
                    r.station_cmd = C_FWD;
                else if (sz == Z_ENTERED)
                begin
                    release_latched = 1'b0;
                    r.station_cmd = C_ZERO;
                end
                r.prestation_cmd = hold_cmd(pz);
                r.ride_cmd = hold_cmd(rz);
            end
            default:
            begin
                // Maintenance sends nothing and leaves the grant alone.
            end
        endcase
        r.mode_now = op_mode;
        expected_cmds.push_back(r);
    endfunction

    function void check_cmds(result_t got);
        result_t want;
        if (expected_cmds.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: result item with nothing outstanding: lift=%0d stn=%0d pre=%0d ride=%0d req=%0d mode=%0d",
                         $realtime, got.lift_cmd, got.station_cmd, got.prestation_cmd,
                         got.ride_cmd, got.release_request, got.mode_now);
            return;
        end
        want = expected_cmds.pop_front();
        if (got.lift_cmd !== want.lift_cmd || got.station_cmd !== want.station_cmd ||
            got.prestation_cmd !== want.prestation_cmd || got.ride_cmd !== want.ride_cmd ||
            got.release_request !== want.release_request || got.mode_now !== want.mode_now)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: mismatch exp lift=%0d stn=%0d pre=%0d ride=%0d req=%0d mode=%0d, got lift=%0d stn=%0d pre=%0d ride=%0d req=%0d mode=%0d",
                         $realtime, want.lift_cmd, want.station_cmd, want.prestation_cmd,
                         want.ride_cmd, want.release_request, want.mode_now,
                         got.lift_cmd, got.station_cmd, got.prestation_cmd,
                         got.ride_cmd, got.release_request, got.mode_now);
        end
    endfunction

    function int pending();
        return expected_cmds.size();
    endfunction
endclass

module tb_top;

    localparam int IdleLimit = 4000;
    localparam int TicksPerPhase = 400;

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    zone_t       lift_zone;
    zone_t       station_zone;
    zone_t       prestation_zone;
    zone_t       ride_zone;
    logic        mode_valid;
    logic [2:0]  mode_code;
    logic        release_granted;
    logic        out_valid;
    logic        out_ready;
    cmd_t        lift_cmd;
    cmd_t        station_cmd;
    cmd_t        prestation_cmd;
    cmd_t        ride_cmd;
    logic        release_request;
    logic [2:0]  mode_now;

    interlock_scoreboard sb;
    int send_idle_pct;
    int recv_stall_pct;
    int quiet_cycles;

    block_zone_interlock dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .lift_zone       (lift_zone),
        .station_zone    (station_zone),
        .prestation_zone (prestation_zone),
        .ride_zone       (ride_zone),
        .mode_valid      (mode_valid),
        .mode_code       (mode_code),
        .release_granted (release_granted),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .lift_cmd        (lift_cmd),
        .station_cmd     (station_cmd),
        .prestation_cmd  (prestation_cmd),
        .ride_cmd        (ride_cmd),
        .release_request (release_request),
        .mode_now        (mode_now)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #2 clk = ~clk;

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Both channels are sampled at the edge, before any update made at that edge.
    always @(posedge clk)
    begin
        result_t got;
        if (rst_n && in_valid && in_ready)
            sb.note_tick(lift_zone, station_zone, prestation_zone, ride_zone,
                         mode_valid, mode_code, release_granted);
        if (rst_n && out_valid && out_ready)
        begin
            got.lift_cmd = lift_cmd;
            got.station_cmd = station_cmd;
            got.prestation_cmd = prestation_cmd;
            got.ride_cmd = ride_cmd;
            got.release_request = release_request;
            got.mode_now = mode_t'(mode_now);
            sb.check_cmds(got);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IdleLimit)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    task automatic send_tick(zone_t lz, zone_t sz, zone_t pz, zone_t rz,
                             logic mv, logic [2:0] mc, logic granted);
        in_valid <= 1'b1;
        lift_zone <= lz;
        station_zone <= sz;
        prestation_zone <= pz;
        ride_zone <= rz;
        mode_valid <= mv;
        mode_code <= mc;
        release_granted <= granted;
        do
            @(posedge clk);
        while (!in_ready);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic zone_t pick_zone();
        // Code three is rare: it only exercises the fall-through paths.
        if ($urandom_range(99) < 6)
            return zone_t'(3);
        return zone_t'($urandom_range(2));
    endfunction

    function automatic logic [2:0] pick_mode();
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return 3'($urandom_range(7, 5));
        if (r < 40)
            return M_AUTO;
        if (r < 72)
            return M_MANUAL;
        if (r < 82)
            return M_STOP;
        if (r < 91)
            return M_SAFE;
        return M_MAINT;
    endfunction

    task automatic random_ticks(int count, bit force_pause);
        for (int i = 0; i < count; i++)
        begin
            while ($urandom_range(99) < send_idle_pct)
            begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
            if ((force_pause && i == count / 2) || $urandom_range(199) == 0)
                wait_drained();
            send_tick(pick_zone(), pick_zone(), pick_zone(), pick_zone(),
                      ($urandom_range(99) < 12), pick_mode(), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        int send_pcts[4];
        int stall_pcts[4];
        send_pcts = '{0, 72, 0, 30};
        stall_pcts = '{0, 0, 72, 30};
        sb = new();
        rst_n = 1'b0;
        in_valid = 1'b0;
        out_ready = 1'b0;
        lift_zone = Z_EMPTY;
        station_zone = Z_EMPTY;
        prestation_zone = Z_EMPTY;
        ride_zone = Z_EMPTY;
        mode_valid = 1'b0;
        mode_code = M_STOP;
        release_granted = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        quiet_cycles = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // Stop mode right after reset, over every zone code.
        send_tick(Z_EMPTY, Z_EMPTY, Z_EMPTY, Z_EMPTY, 1'b0, M_STOP, 1'b0);
        send_tick(Z_ENTERING, Z_ENTERING, Z_ENTERING, Z_ENTERING, 1'b0, M_STOP, 1'b1);
        send_tick(Z_ENTERED, Z_ENTERED, Z_ENTERED, Z_ENTERED, 1'b0, M_STOP, 1'b0);
        send_tick(zone_t'(3), zone_t'(3), zone_t'(3), zone_t'(3), 1'b0, 3'd7, 1'b1);
        // Automatic mode, including the unknown zone code.
        send_tick(Z_EMPTY, Z_ENTERED, Z_ENTERED, Z_EMPTY, 1'b1, M_AUTO, 1'b0);
        send_tick(Z_ENTERED, Z_EMPTY, Z_EMPTY, Z_ENTERED, 1'b0, M_AUTO, 1'b0);
        send_tick(zone_t'(3), zone_t'(3), zone_t'(3), zone_t'(3), 1'b0, M_AUTO, 1'b0);
        // Manual mode: request refused, then granted, then used by the lift.
        send_tick(Z_EMPTY, Z_ENTERED, Z_EMPTY, Z_EMPTY, 1'b1, M_MANUAL, 1'b0);
        send_tick(Z_EMPTY, Z_ENTERED, Z_EMPTY, Z_EMPTY, 1'b0, M_MANUAL, 1'b1);
        send_tick(Z_EMPTY, Z_ENTERED, Z_ENTERED, Z_EMPTY, 1'b0, M_MANUAL, 1'b0);
        send_tick(Z_ENTERING, Z_ENTERED, Z_ENTERING, Z_ENTERED, 1'b0, M_MANUAL, 1'b1);
        send_tick(Z_EMPTY, zone_t'(3), Z_EMPTY, Z_ENTERING, 1'b0, M_MANUAL, 1'b1);
        // Mode codes without meaning leave manual mode in force.
        send_tick(Z_EMPTY, Z_EMPTY, Z_EMPTY, Z_EMPTY, 1'b1, 3'd5, 1'b1);
        send_tick(zone_t'(3), zone_t'(3), zone_t'(3), zone_t'(3), 1'b1, 3'd7, 1'b0);
        send_tick(Z_EMPTY, Z_ENTERED, Z_EMPTY, Z_EMPTY, 1'b1, 3'd6, 1'b1);
        // Maintenance sends nothing.
        send_tick(Z_ENTERED, Z_ENTERED, Z_ENTERED, Z_ENTERED, 1'b1, M_MAINT, 1'b1);
        send_tick(Z_EMPTY, Z_ENTERED, Z_EMPTY, Z_EMPTY, 1'b0, M_MAINT, 1'b0);
        // Return to safe, with the lift entering.
        send_tick(Z_ENTERING, Z_EMPTY, Z_ENTERING, Z_ENTERED, 1'b1, M_SAFE, 1'b0);
        send_tick(Z_EMPTY, Z_ENTERING, Z_EMPTY, Z_ENTERING, 1'b0, M_SAFE, 1'b1);
        send_tick(Z_ENTERED, Z_ENTERED, Z_ENTERED, Z_ENTERED, 1'b0, M_SAFE, 1'b0);
        send_tick(zone_t'(3), zone_t'(3), zone_t'(3), zone_t'(3), 1'b0, M_SAFE, 1'b1);
        send_tick(Z_ENTERING, Z_ENTERING, Z_ENTERED, Z_ENTERED, 1'b1, M_STOP, 1'b1);

        for (int p = 0; p < 4; p++)
        begin
            send_idle_pct = send_pcts[p];
            recv_stall_pct = stall_pcts[p];
            random_ticks(TicksPerPhase, p == 0);
            wait_drained();
        end

        repeat (8) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending() == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

FILE: files.f
design/bzi_pkg.sv
design/bzi_decide.sv
design/block_zone_interlock.sv
tb/tb_top.sv
